@@ design/multicore_job_scheduler_defines.svh @@
// ----------------------------------------------------------------------------
// Multicore job scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTICORE_JOB_SCHEDULER_DEFINES_SVH
`define MULTICORE_JOB_SCHEDULER_DEFINES_SVH

// plain invariant
`define MJS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define MJS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MJS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mjs_pkg.sv @@
// ----------------------------------------------------------------------------
// mjs_pkg
// Types, codes and helpers shared by the job scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mjs_pkg;

  localparam int MAX_CORES   = 8;
  localparam int QUEUE_DEPTH = 64;
  localparam int CORE_W      = 3;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NCORE_W     = $clog2(MAX_CORES + 1);

  localparam logic [1:0] CMD_NEW    = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_EXPIRE = 2'd2;

  localparam logic [2:0] SCH_FCFS = 3'd0;
  localparam logic [2:0] SCH_SJF  = 3'd1;
  localparam logic [2:0] SCH_PSJF = 3'd2;
  localparam logic [2:0] SCH_PRI  = 3'd3;
  localparam logic [2:0] SCH_PPRI = 3'd4;
  localparam logic [2:0] SCH_RR   = 3'd5;

  localparam logic REG_CORE_COUNT = 1'b0;
  localparam logic REG_SCHEME     = 1'b1;

  typedef struct packed {
    logic [15:0] job;
    logic [15:0] arr;
    logic [15:0] rem;
    logic [7:0]  pri;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_PRE_SCAN, ST_SCAN_RD, ST_SCAN_CMP, ST_SCAN_END,
    ST_SHUP_RD, ST_SHUP_WR, ST_INS_WR, ST_HEAD_RD, ST_HEAD_TAKE,
    ST_SHDN_RD, ST_SHDN_WR, ST_PUT_WR, ST_DONE
  } state_t;

  typedef enum logic [1:0] {M_NEW, M_VICTIM, M_EXPIRE, M_FINISH} mode_t;

  // remaining run time after running since dispatch, floored at zero
  function automatic logic [15:0] rem_now(input logic [15:0] rem,
                                          input logic [15:0] dt,
                                          input logic [15:0] t);
    logic [15:0] el;
    el = t - dt;
    return (el >= rem) ? 16'd0 : rem - el;
  endfunction

endpackage

`default_nettype wire

@@ design/mjs_qram.sv @@
// ----------------------------------------------------------------------------
// mjs_qram
// Ready queue store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mjs_qram (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [mjs_pkg::QA_W-1:0] waddr,
  input  wire mjs_pkg::entry_t       wdata,
  input  wire logic [mjs_pkg::QA_W-1:0] raddr,
  output mjs_pkg::entry_t            rdata
);

  mjs_pkg::entry_t mem [mjs_pkg::QUEUE_DEPTH];
  mjs_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/mjs_rank.sv @@
// ----------------------------------------------------------------------------
// mjs_rank
// Shared ordering compare: is entry a strictly ahead of entry b.
// ----------------------------------------------------------------------------
`default_nettype none

module mjs_rank (
  input  wire logic [2:0]      scheme,
  input  wire mjs_pkg::entry_t a,
  input  wire mjs_pkg::entry_t b,
  output logic                 ahead
);

  always_comb begin
    unique case (scheme)
      mjs_pkg::SCH_SJF, mjs_pkg::SCH_PSJF: ahead = a.rem < b.rem;
      mjs_pkg::SCH_PRI, mjs_pkg::SCH_PPRI:
        ahead = (a.pri < b.pri) || ((a.pri == b.pri) && (a.arr < b.arr));
      mjs_pkg::SCH_RR: ahead = 1'b0;
      default:         ahead = a.arr < b.arr;
    endcase
  end

endmodule

`default_nettype wire

@@ design/multicore_job_scheduler.sv @@
// Multicore job scheduler. Each event beat (new job, job finished, quantum
// expired) yields one result beat. A new job that finds an idle core goes
// from decode straight to the result. Anything touching the ready queue walks
// the queue memory one entry at a time, reading each entry before it is compared
// or written, once to find the slot and once to shift entries (taking the head
// only shifts). The worst case is a quantum expiry on a full queue that the
// expired job falls to the back of. The input is not ready meanwhile.
// Preemptive schemes also scan busy cores one per cycle before the queue walk.
// ----------------------------------------------------------------------------
// multicore_job_scheduler
// Top level: config port, event sequencer, core table and ready queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multicore_job_scheduler_defines.svh"

module multicore_job_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // cmd, job_id, current_time, run_length, priority_req, core_index
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,
  // dispatched, target_core, dispatched_job, preempted, overflow
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  mjs_pkg::state_t state_r, state_nxt;
  mjs_pkg::mode_t  mode_r;

  logic [3:0] core_count_r;
  logic [2:0] scheme_r;

  logic [mjs_pkg::MAX_CORES-1:0] busy_r;
  mjs_pkg::entry_t               core_ent_r [mjs_pkg::MAX_CORES];
  logic [15:0]                   core_dt_r  [mjs_pkg::MAX_CORES];

  logic [mjs_pkg::CNT_W-1:0] count_r, idx_r, pos_r;
  logic [mjs_pkg::CORE_W-1:0] core_r;
  mjs_pkg::entry_t cand_r;

  logic [1:0]  cmd_r;
  logic [15:0] job_r, t_r, len_r;
  logic [7:0]  pri_r;
  logic [2:0]  ci_r;

  logic                       res_disp_r, res_pre_r, res_ovf_r;
  logic [mjs_pkg::CORE_W-1:0] res_tgt_r;
  logic [15:0]                res_job_r;

  // config port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  always_comb begin
    unique case (cfg_paddr[2])
      mjs_pkg::REG_CORE_COUNT: cfg_prdata = {28'd0, core_count_r};
      default:                 cfg_prdata = {29'd0, scheme_r};
    endcase
  end

  // core view
  logic [mjs_pkg::NCORE_W-1:0] n_act;
  logic                        idle_found;
  logic [mjs_pkg::CORE_W-1:0]  idle_idx;
  logic                        ci_ok, pre_beats, pre_last, is_pre_sch;
  logic [15:0]                 pre_rem, exp_rem;
  mjs_pkg::entry_t             new_ent, victim_ent;

  always_comb begin
    if (core_count_r == 4'd0) begin
      n_act = mjs_pkg::NCORE_W'(1);
    end else if (core_count_r > 4'(mjs_pkg::MAX_CORES)) begin
      n_act = mjs_pkg::NCORE_W'(mjs_pkg::MAX_CORES);
    end else begin
      n_act = mjs_pkg::NCORE_W'(core_count_r);
    end
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int c = mjs_pkg::MAX_CORES - 1; c >= 0; c--) begin
      if (!busy_r[c] && (mjs_pkg::NCORE_W'(c) < n_act)) begin
        idle_found = 1'b1;
        idle_idx   = mjs_pkg::CORE_W'(c);
      end
    end
  end

  assign ci_ok      = mjs_pkg::NCORE_W'(ci_r) < n_act;
  assign is_pre_sch = (scheme_r == mjs_pkg::SCH_PSJF) || (scheme_r == mjs_pkg::SCH_PPRI);
  assign new_ent    = '{job: job_r, arr: t_r, rem: len_r, pri: pri_r};
  assign pre_rem    = mjs_pkg::rem_now(core_ent_r[core_r].rem, core_dt_r[core_r], t_r);
  assign exp_rem    = mjs_pkg::rem_now(core_ent_r[ci_r].rem, core_dt_r[ci_r], t_r);
  assign pre_beats  = (scheme_r == mjs_pkg::SCH_PPRI) ? (pri_r < core_ent_r[core_r].pri)
                                                      : (len_r < pre_rem);
  assign pre_last   = mjs_pkg::NCORE_W'(core_r) == (n_act - mjs_pkg::NCORE_W'(1));
  assign victim_ent = '{job: core_ent_r[core_r].job, arr: core_ent_r[core_r].arr,
                        rem: pre_rem, pri: core_ent_r[core_r].pri};

  // queue memory and shared compare
  logic                       q_we;
  logic [mjs_pkg::QA_W-1:0]   q_waddr, q_raddr;
  mjs_pkg::entry_t            q_wdata, q_rdata;
  logic                       ahead;

  mjs_qram u_qram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  mjs_rank u_rank (.scheme(scheme_r), .a(cand_r), .b(q_rdata), .ahead(ahead));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mjs_pkg::ST_IDLE: if (in_tvalid) state_nxt = mjs_pkg::ST_DECODE;
      mjs_pkg::ST_DECODE: begin
        if (cmd_r == mjs_pkg::CMD_NEW) begin
          if (idle_found || count_r >= mjs_pkg::CNT_W'(mjs_pkg::QUEUE_DEPTH))
            state_nxt = mjs_pkg::ST_DONE;
          else if (is_pre_sch) state_nxt = mjs_pkg::ST_PRE_SCAN;
          else                 state_nxt = mjs_pkg::ST_SCAN_RD;
        end else if ((cmd_r == mjs_pkg::CMD_FINISH || cmd_r == mjs_pkg::CMD_EXPIRE) && ci_ok)
        begin
          if (cmd_r == mjs_pkg::CMD_EXPIRE && busy_r[ci_r]) state_nxt = mjs_pkg::ST_SCAN_RD;
          else if (count_r != '0) state_nxt = mjs_pkg::ST_HEAD_RD;
          else                    state_nxt = mjs_pkg::ST_DONE;
        end else begin
          state_nxt = mjs_pkg::ST_DONE;
        end
      end
      mjs_pkg::ST_PRE_SCAN: if (pre_beats || pre_last) state_nxt = mjs_pkg::ST_SCAN_RD;
      mjs_pkg::ST_SCAN_RD:
        state_nxt = (idx_r == count_r) ? mjs_pkg::ST_SCAN_END : mjs_pkg::ST_SCAN_CMP;
      mjs_pkg::ST_SCAN_CMP:
        state_nxt = ahead ? mjs_pkg::ST_SCAN_END : mjs_pkg::ST_SCAN_RD;
      mjs_pkg::ST_SCAN_END: begin
        if (mode_r == mjs_pkg::M_EXPIRE)
          state_nxt = (pos_r == '0) ? mjs_pkg::ST_DONE : mjs_pkg::ST_HEAD_RD;
        else
          state_nxt = mjs_pkg::ST_SHUP_RD;
      end
      mjs_pkg::ST_SHUP_RD:
        state_nxt = (idx_r == pos_r) ? mjs_pkg::ST_INS_WR : mjs_pkg::ST_SHUP_WR;
      mjs_pkg::ST_SHUP_WR:   state_nxt = mjs_pkg::ST_SHUP_RD;
      mjs_pkg::ST_INS_WR:    state_nxt = mjs_pkg::ST_DONE;
      mjs_pkg::ST_HEAD_RD:   state_nxt = mjs_pkg::ST_HEAD_TAKE;
      mjs_pkg::ST_HEAD_TAKE: state_nxt = mjs_pkg::ST_SHDN_RD;
      mjs_pkg::ST_SHDN_RD: begin
        if (idx_r == pos_r)
          state_nxt = (mode_r == mjs_pkg::M_EXPIRE) ? mjs_pkg::ST_PUT_WR : mjs_pkg::ST_DONE;
        else
          state_nxt = mjs_pkg::ST_SHDN_WR;
      end
      mjs_pkg::ST_SHDN_WR: state_nxt = mjs_pkg::ST_SHDN_RD;
      mjs_pkg::ST_PUT_WR:  state_nxt = mjs_pkg::ST_DONE;
      mjs_pkg::ST_DONE:    if (out_tready) state_nxt = mjs_pkg::ST_IDLE;
      default:             state_nxt = mjs_pkg::ST_IDLE;
    endcase
  end

  // memory and core-table controls
  logic                       cw_en;
  logic [mjs_pkg::CORE_W-1:0] cw_idx;
  mjs_pkg::entry_t            cw_ent;

  always_comb begin
    q_raddr = idx_r[mjs_pkg::QA_W-1:0];
    q_we    = 1'b0;
    q_waddr = idx_r[mjs_pkg::QA_W-1:0];
    q_wdata = q_rdata;
    cw_en   = 1'b0;
    cw_idx  = core_r;
    cw_ent  = new_ent;
    unique case (state_r)
      mjs_pkg::ST_DECODE: begin
        cw_en  = (cmd_r == mjs_pkg::CMD_NEW) && idle_found;
        cw_idx = idle_idx;
      end
      mjs_pkg::ST_PRE_SCAN: cw_en = pre_beats;
      mjs_pkg::ST_SCAN_END: begin
        cw_en  = (mode_r == mjs_pkg::M_EXPIRE) && (pos_r == '0);
        cw_ent = cand_r;
      end
      mjs_pkg::ST_SHUP_RD: q_raddr = mjs_pkg::QA_W'(idx_r - mjs_pkg::CNT_W'(1));
      mjs_pkg::ST_SHUP_WR: q_we = 1'b1;
      mjs_pkg::ST_INS_WR: begin
        q_we    = 1'b1;
        q_waddr = pos_r[mjs_pkg::QA_W-1:0];
        q_wdata = cand_r;
      end
      mjs_pkg::ST_HEAD_RD: q_raddr = '0;
      mjs_pkg::ST_HEAD_TAKE: begin
        cw_en  = 1'b1;
        cw_ent = q_rdata;
      end
      mjs_pkg::ST_SHDN_WR: begin
        q_we    = 1'b1;
        q_waddr = mjs_pkg::QA_W'(idx_r - mjs_pkg::CNT_W'(1));
      end
      mjs_pkg::ST_PUT_WR: begin
        q_we    = 1'b1;
        q_waddr = mjs_pkg::QA_W'(pos_r - mjs_pkg::CNT_W'(1));
        q_wdata = cand_r;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mjs_pkg::ST_IDLE;
      busy_r       <= '0;
      count_r      <= '0;
      core_count_r <= 4'd1;
      scheme_r     <= mjs_pkg::SCH_FCFS;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == mjs_pkg::REG_CORE_COUNT) core_count_r <= cfg_pwdata[3:0];
        else                                         scheme_r     <= cfg_pwdata[2:0];
      end
      if (state_r == mjs_pkg::ST_DECODE && ci_ok &&
          (cmd_r == mjs_pkg::CMD_FINISH || cmd_r == mjs_pkg::CMD_EXPIRE))
        busy_r[ci_r] <= 1'b0;
      if (cw_en) busy_r[cw_idx] <= 1'b1;
      if (state_r == mjs_pkg::ST_INS_WR) count_r <= count_r + mjs_pkg::CNT_W'(1);
      if (state_r == mjs_pkg::ST_SHDN_RD && idx_r == pos_r && mode_r == mjs_pkg::M_FINISH)
        count_r <= count_r - mjs_pkg::CNT_W'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cw_en) begin
      core_ent_r[cw_idx] <= cw_ent;
      core_dt_r[cw_idx]  <= t_r;
    end
    unique case (state_r)
      mjs_pkg::ST_IDLE: begin
        cmd_r <= in_tdata[1:0];
        job_r <= in_tdata[17:2];
        t_r   <= in_tdata[33:18];
        len_r <= in_tdata[49:34];
        pri_r <= in_tdata[57:50];
        ci_r  <= in_tdata[60:58];
      end
      mjs_pkg::ST_DECODE: begin
        idx_r     <= '0;
        res_pre_r <= 1'b0;
        if (cmd_r == mjs_pkg::CMD_NEW) begin
          core_r     <= '0;
          cand_r     <= new_ent;
          mode_r     <= mjs_pkg::M_NEW;
          res_disp_r <= idle_found;
          res_tgt_r  <= idle_found ? idle_idx : '0;
          res_job_r  <= idle_found ? job_r : 16'd0;
          res_ovf_r  <= !idle_found && (count_r >= mjs_pkg::CNT_W'(mjs_pkg::QUEUE_DEPTH));
        end else begin
          core_r     <= ci_r;
          res_disp_r <= 1'b0;
          res_tgt_r  <= '0;
          res_job_r  <= '0;
          res_ovf_r  <= 1'b0;
          if (cmd_r == mjs_pkg::CMD_EXPIRE && busy_r[ci_r]) begin
            mode_r <= mjs_pkg::M_EXPIRE;
            cand_r <= '{job: core_ent_r[ci_r].job, arr: core_ent_r[ci_r].arr,
                        rem: exp_rem, pri: core_ent_r[ci_r].pri};
          end else begin
            mode_r <= mjs_pkg::M_FINISH;
            cand_r <= new_ent;
            pos_r  <= count_r;
          end
        end
      end
      mjs_pkg::ST_PRE_SCAN: begin
        if (pre_beats) begin
          cand_r     <= victim_ent;
          mode_r     <= mjs_pkg::M_VICTIM;
          res_disp_r <= 1'b1;
          res_tgt_r  <= core_r;
          res_job_r  <= job_r;
          res_pre_r  <= 1'b1;
        end else begin
          core_r <= core_r + mjs_pkg::CORE_W'(1);
        end
      end
      mjs_pkg::ST_SCAN_RD: if (idx_r == count_r) pos_r <= idx_r;
      mjs_pkg::ST_SCAN_CMP: begin
        if (ahead) pos_r <= idx_r;
        else       idx_r <= idx_r + mjs_pkg::CNT_W'(1);
      end
      mjs_pkg::ST_SCAN_END: begin
        idx_r <= count_r;
        if (mode_r == mjs_pkg::M_EXPIRE && pos_r == '0) begin
          res_disp_r <= 1'b1;
          res_tgt_r  <= core_r;
          res_job_r  <= cand_r.job;
        end
      end
      mjs_pkg::ST_SHUP_WR: idx_r <= idx_r - mjs_pkg::CNT_W'(1);
      mjs_pkg::ST_HEAD_TAKE: begin
        res_disp_r <= 1'b1;
        res_tgt_r  <= core_r;
        res_job_r  <= q_rdata.job;
        idx_r      <= mjs_pkg::CNT_W'(1);
      end
      mjs_pkg::ST_SHDN_WR: idx_r <= idx_r + mjs_pkg::CNT_W'(1);
      mjs_pkg::ST_PUT_WR:  res_pre_r <= 1'b1;
      default: ;
    endcase
  end

  assign in_tready  = state_r == mjs_pkg::ST_IDLE;
  assign out_tvalid = state_r == mjs_pkg::ST_DONE;
  assign out_tdata  = {2'b00, res_ovf_r, res_pre_r, res_job_r, res_tgt_r, res_disp_r};

  `MJS_ASSERT(a_count_max, count_r <= mjs_pkg::CNT_W'(mjs_pkg::QUEUE_DEPTH), "queue count past depth")
  `MJS_ASSERT_IMP(a_one_event, out_tvalid, !in_tready, "input ready while result pending")
  `MJS_ASSERT_IMP(a_ovf_alone, out_tvalid && res_ovf_r, !res_disp_r && !res_pre_r, "overflow with dispatch")
  `MJS_ASSERT_NEXT(a_ins_grow, state_r == mjs_pkg::ST_INS_WR, count_r == $past(count_r) + mjs_pkg::CNT_W'(1), "insert did not grow queue")

endmodule

`default_nettype wire
